@@ design/bps_pkg.sv @@
package bps_pkg;

  localparam int unsigned MtuW     = 10;
  localparam int unsigned PortW    = 7;
  localparam int unsigned LenW     = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 2;

  localparam int unsigned HdrBytes = 2;
  localparam int unsigned LenBytes = 4;
  localparam int unsigned MinMtu   = 7;

  localparam logic [MtuW-1:0]  MtuReset     = MtuW'(20);
  localparam logic [PortW-1:0] SrcPortReset = PortW'(1);

  localparam int unsigned DefaultQueueDepth = 4;

  // input word: data_byte, pdu_length, secure, dest_port
  localparam int unsigned InDataW = ByteW + LenW + 1 + PortW;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MTU_SIZE    = 2'd0,
    CFG_SOURCE_PORT = 2'd1
  } cfg_idx_e;

  // what the back end has to emit for one accepted word
  typedef enum logic [1:0] {
    CMD_FIRST,   // header, length, data
    CMD_EMPTY,   // header, length only
    CMD_HDR,     // header, data
    CMD_DATA     // data only
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [ByteW-1:0]  hdr0;
    logic [ByteW-1:0]  hdr1;
    logic [LenW-1:0]   len;
    logic [ByteW-1:0]  data;
    logic              seg_last;
    logic              pdu_last;
  } cmd_t;

endpackage

@@ design/ble_pdu_segmenter_core.sv @@
// channel   | dir | handshake                       | payload
// s_axis    | in  | s_axis_tvalid_i/s_axis_tready_o | tdata: pdu bytes, tuser: pdu_first
// m_axis    | out | m_axis_tvalid_o/m_axis_tready_i | tdata: out_byte, tlast: run_last
// cfg       | in  | cfg_valid_i/cfg_ready_o         | cfg_index_i, cfg_data_i
//
// one input word is taken per cycle while the command queue has room
// a first word emits 7 bytes (6 for a zero-length pdu), a word opening a later segment
// 3, any other payload word 1; the back end sends one byte a cycle while m_axis is
// ready; m_axis stalls back up through the output register into the queue, then s_axis
// reset clears segment state and loads mtu 20, source port 1
module ble_pdu_segmenter_core #(
  parameter int unsigned QueueDepth = bps_pkg::DefaultQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bps_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bps_pkg::MtuW-1:0]      cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // data_byte[7:0], pdu_length[39:8], secure[40], dest_port[47:41]
  input  logic [bps_pkg::InDataW-1:0]   s_axis_tdata_i,
  // pdu_first[0]
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // out_byte[7:0]
  output logic [bps_pkg::ByteW-1:0]     m_axis_tdata_o,
  // segment_last[0], pdu_last[1]
  output logic [1:0]                    m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);

  logic          push_valid, push_ready, pop_valid, pop_ready;
  bps_pkg::cmd_t push_cmd, pop_cmd;
  logic          seg_last, pdu_last;

  assign cfg_ready_o = 1'b1;

  bps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .data_byte_i  (s_axis_tdata_i[7:0]),
    .pdu_first_i  (s_axis_tuser_i),
    .pdu_length_i (s_axis_tdata_i[39:8]),
    .secure_i     (s_axis_tdata_i[40]),
    .dest_port_i  (s_axis_tdata_i[47:41]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  bps_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  bps_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (pop_valid),
    .cmd_ready_o    (pop_ready),
    .cmd_i          (pop_cmd),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_byte_o     (m_axis_tdata_o),
    .segment_last_o (seg_last),
    .pdu_last_o     (pdu_last),
    .run_last_o     (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = {pdu_last, seg_last};

endmodule

@@ design/bps_front.sv @@
module bps_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write
  input  logic                                cfg_valid_i,
  input  logic [bps_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [bps_pkg::MtuW-1:0]            cfg_data_i,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bps_pkg::ByteW-1:0]           data_byte_i,
  input  logic                                pdu_first_i,
  input  logic [bps_pkg::LenW-1:0]            pdu_length_i,
  input  logic                                secure_i,
  input  logic [bps_pkg::PortW-1:0]           dest_port_i,
  // command push
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output bps_pkg::cmd_t                       push_cmd_o
);

  logic [bps_pkg::MtuW-1:0]  mtu_q, mtu_eff;
  logic [bps_pkg::PortW-1:0] src_port_q;

  logic [bps_pkg::LenW-1:0]  rem_q, rem_d, rem_base, rem_dec;
  logic [bps_pkg::MtuW-1:0]  fill_q, fill_d, fill_base, fill_inc;
  logic [bps_pkg::PortW-1:0] held_dest_q, held_dest_d;
  logic                      held_sec_q, held_sec_d;
  logic                      in_acc, pdu_l, seg_l;

  assign in_ready_o = push_ready_i;
  assign in_acc     = in_valid_i && push_ready_i;
  assign mtu_eff    = (mtu_q < bps_pkg::MtuW'(bps_pkg::MinMtu)) ?
                      bps_pkg::MtuW'(bps_pkg::MinMtu) : mtu_q;

  always_comb begin
    rem_base  = pdu_first_i ? pdu_length_i : rem_q;
    if (pdu_first_i) begin
      fill_base = bps_pkg::MtuW'(bps_pkg::HdrBytes + bps_pkg::LenBytes);
    end else if (fill_q == '0) begin
      fill_base = bps_pkg::MtuW'(bps_pkg::HdrBytes);
    end else begin
      fill_base = fill_q;
    end
    rem_dec  = rem_base - bps_pkg::LenW'(1);
    fill_inc = fill_base + bps_pkg::MtuW'(1);
    pdu_l    = (rem_dec == '0);
    seg_l    = (fill_inc >= mtu_eff) || pdu_l;
  end

  always_comb begin
    rem_d       = rem_q;
    fill_d      = fill_q;
    held_dest_d = held_dest_q;
    held_sec_d  = held_sec_q;
    push_valid_o = 1'b0;

    push_cmd_o.kind     = bps_pkg::CMD_DATA;
    push_cmd_o.hdr0     = {pdu_first_i, src_port_q};
    push_cmd_o.hdr1     = pdu_first_i ? {secure_i, dest_port_i} : {held_sec_q, held_dest_q};
    push_cmd_o.len      = pdu_length_i;
    push_cmd_o.data     = data_byte_i;
    push_cmd_o.seg_last = seg_l;
    push_cmd_o.pdu_last = pdu_l;

    if (in_acc) begin
      if (pdu_first_i) begin
        held_dest_d  = dest_port_i;
        held_sec_d   = secure_i;
        push_valid_o = 1'b1;
        if (pdu_length_i == '0) begin
          push_cmd_o.kind = bps_pkg::CMD_EMPTY;
          rem_d  = '0;
          fill_d = '0;
        end else begin
          push_cmd_o.kind = bps_pkg::CMD_FIRST;
          rem_d  = rem_dec;
          fill_d = seg_l ? '0 : fill_inc;
        end
      end else if (rem_q != '0) begin
        // stray bytes with nothing left to send are dropped
        push_valid_o    = 1'b1;
        push_cmd_o.kind = (fill_q == '0) ? bps_pkg::CMD_HDR : bps_pkg::CMD_DATA;
        rem_d  = rem_dec;
        fill_d = seg_l ? '0 : fill_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q       <= bps_pkg::MtuReset;
      src_port_q  <= bps_pkg::SrcPortReset;
      rem_q       <= '0;
      fill_q      <= '0;
      held_dest_q <= '0;
      held_sec_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          bps_pkg::CFG_MTU_SIZE:    mtu_q      <= cfg_data_i;
          bps_pkg::CFG_SOURCE_PORT: src_port_q <= cfg_data_i[bps_pkg::PortW-1:0];
          default: ;
        endcase
      end
      rem_q       <= rem_d;
      fill_q      <= fill_d;
      held_dest_q <= held_dest_d;
      held_sec_q  <= held_sec_d;
    end
  end

endmodule

@@ design/bps_queue.sv @@
module bps_queue #(
  parameter int unsigned Depth = bps_pkg::DefaultQueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  bps_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output bps_pkg::cmd_t pop_cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bps_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

@@ design/bps_back.sv @@
module bps_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  bps_pkg::cmd_t               cmd_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bps_pkg::ByteW-1:0]   out_byte_o,
  output logic                        segment_last_o,
  output logic                        pdu_last_o,
  output logic                        run_last_o
);

  typedef enum logic [2:0] {
    ST_HDR0, ST_HDR1, ST_LEN3, ST_LEN2, ST_LEN1, ST_LEN0, ST_DATA
  } step_e;

  step_e step_q, step_cur, step_nxt;
  logic  busy_q;
  logic  out_valid_q, seg_last_q, pdu_last_q, run_last_q;
  logic [bps_pkg::ByteW-1:0] byte_q;

  logic                      advance, emit, is_last;
  logic [bps_pkg::ByteW-1:0] sel_byte;
  logic                      sel_seg, sel_pdu;

  assign advance = !out_valid_q || out_ready_i;
  assign emit    = advance && cmd_valid_i;

  always_comb begin
    if (busy_q) begin
      step_cur = step_q;
    end else if (cmd_i.kind == bps_pkg::CMD_DATA) begin
      step_cur = ST_DATA;
    end else begin
      step_cur = ST_HDR0;
    end

    is_last  = (step_cur == ST_DATA) ||
               ((step_cur == ST_LEN0) && (cmd_i.kind == bps_pkg::CMD_EMPTY));

    sel_seg  = 1'b0;
    sel_pdu  = 1'b0;
    step_nxt = ST_DATA;
    unique case (step_cur)
      ST_HDR0: begin
        sel_byte = cmd_i.hdr0;
        step_nxt = ST_HDR1;
      end
      ST_HDR1: begin
        sel_byte = cmd_i.hdr1;
        step_nxt = (cmd_i.kind == bps_pkg::CMD_HDR) ? ST_DATA : ST_LEN3;
      end
      ST_LEN3: begin
        sel_byte = cmd_i.len[31:24];
        step_nxt = ST_LEN2;
      end
      ST_LEN2: begin
        sel_byte = cmd_i.len[23:16];
        step_nxt = ST_LEN1;
      end
      ST_LEN1: begin
        sel_byte = cmd_i.len[15:8];
        step_nxt = ST_LEN0;
      end
      ST_LEN0: begin
        sel_byte = cmd_i.len[7:0];
        // zero-length pdu closes on its last length byte
        sel_seg  = (cmd_i.kind == bps_pkg::CMD_EMPTY);
        sel_pdu  = (cmd_i.kind == bps_pkg::CMD_EMPTY);
        step_nxt = ST_DATA;
      end
      ST_DATA: begin
        sel_byte = cmd_i.data;
        sel_seg  = cmd_i.seg_last;
        sel_pdu  = cmd_i.pdu_last;
        step_nxt = ST_DATA;
      end
      default: begin
        sel_byte = cmd_i.data;
      end
    endcase
  end

  assign cmd_ready_o = advance && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_HDR0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= cmd_valid_i;
      if (emit) begin
        busy_q <= !is_last;
        step_q <= step_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q     <= sel_byte;
      seg_last_q <= sel_seg;
      pdu_last_q <= sel_pdu;
      run_last_q <= is_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = byte_q;
  assign segment_last_o = seg_last_q;
  assign pdu_last_o     = pdu_last_q;
  assign run_last_o     = run_last_q;

endmodule

@@ test/ble_pdu_segmenter_core_tb.sv @@
module ble_pdu_segmenter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned LongHold    = 300;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_e;

  typedef struct packed {
    logic [bps_pkg::PortW-1:0] dest;
    logic                      secure;
    logic [bps_pkg::LenW-1:0]  len;
    logic [bps_pkg::ByteW-1:0] data;
    logic                      first;
  } pdu_word_t;

  typedef struct packed {
    logic [bps_pkg::ByteW-1:0] value;
    logic                      seg_end;
    logic                      pdu_end;
    logic                      run_end;
  } seg_byte_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready_o;
  bps_pkg::cfg_idx_e            cfg_index = bps_pkg::CFG_MTU_SIZE;
  logic [bps_pkg::MtuW-1:0]     cfg_data = '0;
  logic                         s_valid = 1'b0;
  logic                         s_axis_tready_o;
  logic [bps_pkg::InDataW-1:0]  s_tdata = '0;
  logic                         s_tuser = 1'b0;
  logic                         m_axis_tvalid_o;
  logic                         m_ready = 1'b0;
  logic [bps_pkg::ByteW-1:0]    m_axis_tdata_o;
  logic [1:0]                   m_axis_tuser_o;
  logic                         m_axis_tlast_o;

  pdu_word_t   pdu_words_todo[$];
  seg_byte_t   seg_bytes_due[$];
  idle_e       idle_mode = IDLE_NONE;
  int unsigned n_err = 0;
  int unsigned quiet_cycles = 0;
  logic        hold_req = 1'b0;

  // segmenter state as the block should hold it
  logic [bps_pkg::MtuW-1:0]  mtu_reg = bps_pkg::MtuReset;
  logic [bps_pkg::PortW-1:0] src_port = bps_pkg::SrcPortReset;
  logic [bps_pkg::LenW-1:0]  rem_bytes = '0;
  logic [bps_pkg::MtuW-1:0]  seg_fill = '0;
  logic [bps_pkg::PortW-1:0] held_dest = '0;
  logic                      held_sec = 1'b0;

  ble_pdu_segmenter_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic seg_byte_t mk_out(input logic [bps_pkg::ByteW-1:0] value,
                                       input logic seg_end, input logic pdu_end);
    seg_byte_t b;
    b.value   = value;
    b.seg_end = seg_end;
    b.pdu_end = pdu_end;
    b.run_end = 1'b0;
    return b;
  endfunction

  // expected output bytes for one accepted input word
  function automatic void segment_word(input pdu_word_t w);
    seg_byte_t                run[$];
    logic [bps_pkg::MtuW-1:0] lim;
    logic                     done_pdu;
    logic                     zero_len;
    lim = (mtu_reg < bps_pkg::MtuW'(bps_pkg::MinMtu)) ?
          bps_pkg::MtuW'(bps_pkg::MinMtu) : mtu_reg;
    zero_len = w.first && (w.len == '0);
    if (w.first) begin
      held_sec  = w.secure;
      held_dest = w.dest;
      rem_bytes = w.len;
      run.push_back(mk_out({1'b1, src_port}, 1'b0, 1'b0));
      run.push_back(mk_out({held_sec, held_dest}, 1'b0, 1'b0));
      for (int i = bps_pkg::LenBytes - 1; i >= 0; i--) begin
        run.push_back(mk_out(w.len[8*i +: 8], zero_len && i == 0, zero_len && i == 0));
      end
      seg_fill = bps_pkg::MtuW'(bps_pkg::HdrBytes + bps_pkg::LenBytes);
    end else if (rem_bytes != '0 && seg_fill == '0) begin
      run.push_back(mk_out({1'b0, src_port}, 1'b0, 1'b0));
      run.push_back(mk_out({held_sec, held_dest}, 1'b0, 1'b0));
      seg_fill = bps_pkg::MtuW'(bps_pkg::HdrBytes);
    end
    if (zero_len) begin
      seg_fill = '0;
    end else if (rem_bytes != '0) begin
      seg_fill  = seg_fill + 1'b1;
      rem_bytes = rem_bytes - 1'b1;
      done_pdu  = (rem_bytes == '0);
      run.push_back(mk_out(w.data, seg_fill >= lim || done_pdu, done_pdu));
      if (seg_fill >= lim || done_pdu) seg_fill = '0;
    end
    if (run.size() != 0) begin
      run[run.size()-1].run_end = 1'b1;
      foreach (run[i]) seg_bytes_due.push_back(run[i]);
    end
  endfunction

  function automatic bit gap_now(input bit recv_side);
    int unsigned pct;
    unique case (idle_mode)
      IDLE_SEND: pct = recv_side ? 0 : 46;
      IDLE_RECV: pct = recv_side ? 46 : 0;
      IDLE_BOTH: pct = 24;
      default:   pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic pdu_word_t mk_word(input logic first,
                                        input logic [bps_pkg::ByteW-1:0] data,
                                        input logic [bps_pkg::LenW-1:0] len, input logic sec,
                                        input logic [bps_pkg::PortW-1:0] dest);
    pdu_word_t w;
    w.first  = first;
    w.data   = data;
    w.len    = len;
    w.secure = sec;
    w.dest   = dest;
    return w;
  endfunction

  // continuation word; the sampled-on-first fields carry noise
  function automatic pdu_word_t junk_word();
    return mk_word(1'b0, bps_pkg::ByteW'($urandom), $urandom, 1'($urandom),
                   bps_pkg::PortW'($urandom));
  endfunction

  function automatic void add_pdu(input int unsigned len);
    pdu_words_todo.push_back(mk_word(1'b1, bps_pkg::ByteW'($urandom), len, 1'($urandom),
                                     bps_pkg::PortW'($urandom)));
    for (int unsigned k = 1; k < len; k++) pdu_words_todo.push_back(junk_word());
  endfunction

  function automatic void add_mix(input int unsigned n_words);
    int unsigned cnt;
    int unsigned pick;
    int unsigned k;
    cnt = 0;
    while (cnt < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 64) begin
        k = (pick < 6) ? $urandom_range(41, 120) : $urandom_range(1, 40);
        add_pdu(k);
        cnt += k;
      end else if (pick < 72) begin
        add_pdu(0);
        cnt++;
      end else if (pick < 80) begin
        // strays, or tail bytes of a pdu cut short before
        repeat ($urandom_range(1, 3)) pdu_words_todo.push_back(junk_word());
      end else begin
        // long pdu abandoned by the next first word
        k = $urandom_range(0, 8);
        pdu_words_todo.push_back(mk_word(1'b1, bps_pkg::ByteW'($urandom),
                                         (pick < 90) ? $urandom : 32'hFFFF_FFFF,
                                         1'($urandom), bps_pkg::PortW'($urandom)));
        repeat (k) pdu_words_todo.push_back(junk_word());
        cnt += k + 1;
      end
    end
  endfunction

  task automatic write_reg(input bps_pkg::cfg_idx_e idx,
                           input logic [bps_pkg::MtuW-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    unique case (idx)
      bps_pkg::CFG_MTU_SIZE:    mtu_reg = val;
      bps_pkg::CFG_SOURCE_PORT: src_port = val[bps_pkg::PortW-1:0];
      default: ;
    endcase
  endtask

  // checked at the falling edge so queue pops and valid updates have settled
  task automatic drain();
    while (pdu_words_todo.size() != 0 || s_valid || seg_bytes_due.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [bps_pkg::MtuW-1:0] mtu,
                           input logic [bps_pkg::PortW-1:0] port,
                           input idle_e mode, input int unsigned n_words,
                           input int unsigned long_len);
    write_reg(bps_pkg::CFG_MTU_SIZE, mtu);
    write_reg(bps_pkg::CFG_SOURCE_PORT, bps_pkg::MtuW'(port));
    idle_mode <= mode;
    if (long_len != 0) add_pdu(long_len);
    add_mix(n_words);
    // close on a complete pdu so the next settings start clean
    add_pdu($urandom_range(1, 30));
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // below the minimum, so the block works with seven
    write_reg(bps_pkg::CFG_MTU_SIZE, bps_pkg::MtuW'(3));
    // stray word with nothing open
    pdu_words_todo.push_back(mk_word(1'b0, 8'h55, 32'd0, 1'b0, 7'd0));
    // zero-length pdu
    pdu_words_todo.push_back(mk_word(1'b1, 8'hFF, 32'd0, 1'b1, 7'd127));
    // one-byte pdu to the multicast port
    pdu_words_todo.push_back(mk_word(1'b1, 8'h00, 32'd1, 1'b0, 7'd0));
    // three segments at the smallest mtu, then one word past the end
    pdu_words_todo.push_back(mk_word(1'b1, 8'hFF, 32'd8, 1'b1, 7'h2A));
    repeat (8) pdu_words_todo.push_back(junk_word());
    // longest length, abandoned by a restart
    pdu_words_todo.push_back(mk_word(1'b1, 8'hA5, 32'hFFFF_FFFF, 1'b0, 7'd127));
    repeat (2) pdu_words_todo.push_back(junk_word());
    pdu_words_todo.push_back(mk_word(1'b1, 8'h5A, 32'd2, 1'b1, 7'd1));
    pdu_words_todo.push_back(junk_word());
    drain();

    run_phase(bps_pkg::MtuW'(bps_pkg::MinMtu), 7'd127, IDLE_NONE, 24, 0);
    run_phase(bps_pkg::MtuW'(517), 7'd0, IDLE_SEND, 24, 0);
    run_phase(bps_pkg::MtuW'(1023), 7'd64, IDLE_RECV, 24, 0);
    run_phase(bps_pkg::MtuW'(0), 7'd1, IDLE_BOTH, 24, 0);
    hold_req <= 1'b1;
    run_phase(bps_pkg::MtuW'($urandom_range(7, 40)),
              bps_pkg::PortW'($urandom_range(1, 127)), IDLE_NONE, 24, 0);
    run_phase(bps_pkg::MtuReset, bps_pkg::PortW'($urandom_range(1, 127)), IDLE_BOTH, 24, 0);
    run_phase(bps_pkg::MtuW'($urandom_range(7, 64)),
              bps_pkg::PortW'($urandom_range(0, 127)), IDLE_RECV, 24, 0);

    if (n_err == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  always @(posedge clk_i) begin : drive_p
    pdu_word_t cur_word;
    logic      offer;
    if (rst_ni) begin
      offer = s_valid;
      if (s_valid && s_axis_tready_o) begin
        segment_word(cur_word);
        offer = 1'b0;
      end
      if (!offer && pdu_words_todo.size() != 0 && !gap_now(1'b0)) begin
        cur_word = pdu_words_todo.pop_front();
        offer = 1'b1;
      end
      s_valid <= offer;
      s_tdata <= {cur_word.dest, cur_word.secure, cur_word.len, cur_word.data};
      s_tuser <= cur_word.first;
    end
  end

  always @(posedge clk_i) begin : sink_p
    seg_byte_t   got;
    seg_byte_t   want;
    logic        rdy;
    int unsigned hold_left;
    bit          hold_used;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_ready) begin
        got = {m_axis_tdata_o, m_axis_tuser_o[0], m_axis_tuser_o[1], m_axis_tlast_o};
        if (seg_bytes_due.size() == 0) begin
          $display("%0t: expected no word, got byte %h seg %b pdu %b run %b", $time,
                   got.value, got.seg_end, got.pdu_end, got.run_end);
          n_err++;
        end else begin
          want = seg_bytes_due.pop_front();
          if (got !== want) begin
            $display("%0t: expected %h seg %b pdu %b run %b, got %h seg %b pdu %b run %b",
                     $time, want.value, want.seg_end, want.pdu_end, want.run_end,
                     got.value, got.seg_end, got.pdu_end, got.run_end);
            n_err++;
          end
        end
      end
      // one long hold-off lets the block fill up and push back on its input
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = LongHold;
        rdy = 1'b0;
      end else begin
        rdy = !gap_now(1'b1);
      end
      m_ready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready) ||
          (cfg_valid && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
